FILE: design/wwc_pkg.sv
// Package for the whitespace word counter.
// Holds field widths, whitespace codes, the lane and scan structs and the
// whitespace test. No dependencies.
package wwc_pkg;

   // Field widths of the request and response words
   localparam int DATA_WIDTH   = 64;
   localparam int VCOUNT_WIDTH = 4;
   localparam int OUT_WIDTH    = 32;
   localparam int DONE_WIDTH   = 3;

   // Lane limits set by the 64-bit data field
   localparam int MAX_LANES = 8;
   localparam int LCNT_W    = 4;
   localparam int LIDX_W    = 3;

   // Defaults for the top-level parameters
   localparam int BYTE_LANES_DEF  = 8;
   localparam int COUNT_WIDTH_DEF = 32;

   // Whitespace codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // Per-byte classification from one lane
   typedef struct packed {
      logic ns;      // valid byte, part of a word
      logic sp;      // valid byte, whitespace
      logic opens;   // word starts here (previous lane not in a word)
      logic closes;  // whitespace ends a word from the previous lane
   } lane_type;

   // Item summary handed from the scan stage to the merge stage
   typedef struct packed {
      logic              ns_first;
      logic              sp_first;
      logic [LCNT_W-1:0] inner_closes;
      logic              inner_start_any;
      logic [LIDX_W-1:0] inner_start_lane;
      logic [LCNT_W-1:0] inner_suffix;
      logic [LCNT_W-1:0] ns_total;
      logic [LCNT_W-1:0] byte_count;
      logic              tail_ns;
      logic              last_item;
   } scan_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR);
   endfunction

endpackage

FILE: design/wwc_if.sv
// Valid/ready channel interfaces for the word counter's request and response.
// Depends on wwc_pkg for field widths.
interface wwc_req_if;
   import wwc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   data_bytes;
   logic [VCOUNT_WIDTH-1:0] valid_count;
   logic                    last_item;

   modport source (output valid, data_bytes, valid_count, last_item, input ready);
   modport sink   (input valid, data_bytes, valid_count, last_item, output ready);
endinterface

interface wwc_rsp_if;
   import wwc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OUT_WIDTH-1:0]  total_words;
   logic [DONE_WIDTH-1:0] words_completed;
   logic                  open_word;
   logic [OUT_WIDTH-1:0]  latest_length;
   logic [OUT_WIDTH-1:0]  latest_start;

   modport source (output valid, total_words, words_completed, open_word, latest_length,
                   latest_start, input ready);
   modport sink   (input valid, total_words, words_completed, open_word, latest_length,
                   latest_start, output ready);
endinterface

FILE: design/wwc_lane.sv
// One byte lane: classifies a byte and marks word starts and ends
// against the neighbouring lane. Depends on wwc_pkg.
module wwc_lane (
   input  logic [7:0]        lane_byte,
   input  logic              lane_valid,
   input  logic              prev_ns,
   output wwc_pkg::lane_type lane_res
);
   import wwc_pkg::*;

   logic space;

   // Classify, then compare with the previous lane
   always_comb begin
      space           = is_space(lane_byte);
      lane_res.ns     = lane_valid & ~space;
      lane_res.sp     = lane_valid & space;
      lane_res.opens  = lane_valid & ~space & ~prev_ns;
      lane_res.closes = lane_valid & space & prev_ns;
   end

endmodule

FILE: design/wwc_scan.sv
// Scan stage: byte lanes side by side and a registered summary of the word.
// Everything here depends on the request word alone. Depends on wwc_pkg, wwc_lane.
module wwc_scan #(
   parameter int BYTE_LANES = wwc_pkg::BYTE_LANES_DEF
) (
   input  logic                            clock,
   input  logic                            load,
   input  logic [wwc_pkg::DATA_WIDTH-1:0]  data_bytes,
   input  logic [wwc_pkg::VCOUNT_WIDTH-1:0] valid_count,
   input  logic                            last_item,
   output wwc_pkg::scan_type               scan_ff
);
   import wwc_pkg::*;

   logic [LCNT_W-1:0] byte_count;
   lane_type          lane_res [BYTE_LANES];
   scan_type          scan_in;

   // Clamp the byte count to the lane count
   assign byte_count = (valid_count > LCNT_W'(BYTE_LANES)) ? LCNT_W'(BYTE_LANES)
                                                           : valid_count;

   // Lanes
   for (genvar g = 0; g < BYTE_LANES; g++) begin : g_lane
      logic prev;
      if (g == 0) begin : g_first
         assign prev = 1'b0;
      end else begin : g_rest
         assign prev = lane_res[g-1].ns;
      end
      wwc_lane u_lane (
         .lane_byte  (data_bytes[8*g +: 8]),
         .lane_valid (LCNT_W'(g) < byte_count),
         .prev_ns    (prev),
         .lane_res   (lane_res[g])
      );
   end

   // Reduce lane flags; lane 0 is resolved later against the carried state
   always_comb begin
      scan_in                  = '0;
      scan_in.ns_first         = lane_res[0].ns;
      scan_in.sp_first         = lane_res[0].sp;
      scan_in.byte_count       = byte_count;
      scan_in.last_item        = last_item;
      scan_in.tail_ns          = lane_res[0].ns;
      scan_in.ns_total         = LCNT_W'(lane_res[0].ns);
      scan_in.inner_suffix     = LCNT_W'(lane_res[0].ns);
      for (int i = 1; i < BYTE_LANES; i++) begin
         scan_in.inner_closes = scan_in.inner_closes + LCNT_W'(lane_res[i].closes);
         scan_in.ns_total     = scan_in.ns_total + LCNT_W'(lane_res[i].ns);
         if (lane_res[i].opens) begin
            scan_in.inner_start_any  = 1'b1;
            scan_in.inner_start_lane = LIDX_W'(i);
            scan_in.inner_suffix     = '0;
         end
         scan_in.inner_suffix = scan_in.inner_suffix + LCNT_W'(lane_res[i].ns);
         if (lane_res[i].ns || lane_res[i].sp) begin
            scan_in.tail_ns = lane_res[i].ns;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         scan_ff <= scan_in;
      end
   end

endmodule

FILE: design/wwc_merge.sv
// Merge stage: folds the scan summary into the carried word state and
// registers the response payload. Depends on wwc_pkg.
module wwc_merge #(
   parameter int COUNT_WIDTH = wwc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  wwc_pkg::scan_type             scan,
   output logic [wwc_pkg::OUT_WIDTH-1:0]  total_words_ff,
   output logic [wwc_pkg::DONE_WIDTH-1:0] words_completed_ff,
   output logic                          open_word_ff,
   output logic [wwc_pkg::OUT_WIDTH-1:0]  latest_length_ff,
   output logic [wwc_pkg::OUT_WIDTH-1:0]  latest_start_ff
);
   import wwc_pkg::*;

   localparam int SUM_W = COUNT_WIDTH + 1;

   logic                   inside_ff, inside_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] length_ff, length_in;
   logic [COUNT_WIDTH-1:0] start_ff, start_in;
   logic [COUNT_WIDTH-1:0] offset_ff, offset_in;

   logic              start_first, close_first, inside_after, flush, any_start;
   logic [LCNT_W-1:0] done;
   logic [LCNT_W-1:0] start_lane;

   // Saturating add of a small amount
   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] v,
                                                      input logic [LCNT_W-1:0] k);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, v} + SUM_W'(k);
      return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
   endfunction

   // Resolve lane 0 against the carried flag and update the state
   always_comb begin
      start_first  = scan.ns_first & ~inside_ff;
      close_first  = scan.sp_first & inside_ff;
      inside_after = (scan.byte_count != '0) ? scan.tail_ns : inside_ff;
      flush        = scan.last_item & inside_after;
      done         = scan.inner_closes + LCNT_W'(close_first) + LCNT_W'(flush);
      any_start    = scan.inner_start_any | start_first;
      start_lane   = scan.inner_start_any ? LCNT_W'(scan.inner_start_lane) : '0;

      inside_in = inside_after & ~scan.last_item;
      count_in  = sat_add(count_ff, done);
      offset_in = sat_add(offset_ff, scan.byte_count);
      if (any_start) begin
         start_in  = sat_add(offset_ff, start_lane);
         length_in = scan.inner_start_any ? COUNT_WIDTH'(scan.inner_suffix)
                                          : COUNT_WIDTH'(scan.ns_total);
      end else begin
         start_in  = start_ff;
         length_in = sat_add(length_ff, scan.ns_total);
      end
   end

   // Carried state
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         count_ff  <= '0;
         length_ff <= '0;
         start_ff  <= '0;
         offset_ff <= '0;
      end else if (load) begin
         inside_ff <= inside_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (load) begin
         total_words_ff     <= OUT_WIDTH'(count_in);
         words_completed_ff <= DONE_WIDTH'(done);
         open_word_ff       <= inside_in;
         latest_length_ff   <= OUT_WIDTH'(length_in);
         latest_start_ff    <= OUT_WIDTH'(start_in);
      end
   end

endmodule

FILE: design/whitespace_word_counter.sv
// Whitespace word counter: counts words in a text stream, eight bytes per word.
// A request word is registered in the scan stage, then the merge stage registers its response.
// One word per cycle while the response channel is free; the word state loops within the merge stage.
// While a response waits, one more request is taken into an empty scan stage, then ready drops.
// Synchronous reset clears the word state, the counters and both stage valid flags.
// Depends on wwc_pkg, wwc_if, wwc_scan and wwc_merge.
module whitespace_word_counter #(
   parameter int BYTE_LANES  = wwc_pkg::BYTE_LANES_DEF,
   parameter int COUNT_WIDTH = wwc_pkg::COUNT_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   wwc_req_if.sink   req_chan,
   wwc_rsp_if.source rsp_chan
);
   import wwc_pkg::*;

   logic     scan_valid_ff, scan_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_free, scan_free, req_take, scan_move;
   scan_type scan;

   // Stall chain: each stage moves when the next one is free
   assign rsp_free  = ~rsp_valid_ff | rsp_chan.ready;
   assign scan_move = scan_valid_ff & rsp_free;
   assign scan_free = ~scan_valid_ff | rsp_free;
   assign req_take  = req_chan.valid & scan_free;

   assign req_chan.ready = scan_free;
   assign rsp_chan.valid = rsp_valid_ff;

   always_comb begin
      scan_valid_in = scan_free ? req_chan.valid : scan_valid_ff;
      rsp_valid_in  = rsp_free ? scan_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   wwc_scan #(.BYTE_LANES(BYTE_LANES)) u_scan (
      .clock       (clock),
      .load        (req_take),
      .data_bytes  (req_chan.data_bytes),
      .valid_count (req_chan.valid_count),
      .last_item   (req_chan.last_item),
      .scan_ff     (scan)
   );

   wwc_merge #(.COUNT_WIDTH(COUNT_WIDTH)) u_merge (
      .clock              (clock),
      .reset              (reset),
      .load               (scan_move),
      .scan               (scan),
      .total_words_ff     (rsp_chan.total_words),
      .words_completed_ff (rsp_chan.words_completed),
      .open_word_ff       (rsp_chan.open_word),
      .latest_length_ff   (rsp_chan.latest_length),
      .latest_start_ff    (rsp_chan.latest_start)
   );

   // An accepted word lands in the scan stage
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> scan_valid_ff)
      else $error("accepted word not held in scan stage");

   // A stalled scan word stays put
   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      scan_valid_ff && !rsp_free |=> scan_valid_ff && $stable(scan))
      else $error("scan stage lost a stalled word");

   // At most five words can end within one eight-byte word
   a_done_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.words_completed <= DONE_WIDTH'(5))
      else $error("too many words completed");

   // An open word always has a length
   a_open_len: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.open_word |-> rsp_chan.latest_length != '0)
      else $error("open word with zero length");

   // Empty pipeline always takes a request
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !scan_valid_ff && !rsp_valid_ff |-> req_chan.ready)
      else $error("idle pipeline refused a word");

endmodule

FILE: tb/sv/whitespace_word_counter_checker.sv
// Checker for the whitespace word counter: watches both channels, predicts each response word
// from the accepted request words and compares it field by field.
// Depends on wwc_pkg and wwc_if.
module whitespace_word_counter_checker (
   input  logic clock,
   input  logic reset,
   wwc_req_if   req,
   wwc_rsp_if   rsp,
   output int   fail_count,
   output int   expect_depth
);
   timeunit 1ns;
   timeprecision 1ps;
   import wwc_pkg::*;

   localparam logic [OUT_WIDTH-1:0] CNT_MAX = '1;

   // One predicted response word
   typedef struct packed {
      logic [OUT_WIDTH-1:0]  total_words;
      logic [DONE_WIDTH-1:0] words_completed;
      logic                  open_word;
      logic [OUT_WIDTH-1:0]  latest_length;
      logic [OUT_WIDTH-1:0]  latest_start;
   } tally_t;

   // Predicted stream state
   logic                 in_word;
   logic [OUT_WIDTH-1:0] word_total;
   logic [OUT_WIDTH-1:0] cur_len;
   logic [OUT_WIDTH-1:0] cur_start;
   logic [OUT_WIDTH-1:0] byte_pos;

   tally_t tally_q[$];
   tally_t want;

   initial begin
      fail_count   = 0;
      expect_depth = 0;
   end

   function automatic logic [OUT_WIDTH-1:0] bump(input logic [OUT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic blank(input logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR;
   endfunction

   // Scan one request word and queue the response it should give
   task automatic scan_word(input logic [DATA_WIDTH-1:0] d, input logic [VCOUNT_WIDTH-1:0] cnt,
                            input logic fin);
      int                    lanes;
      logic [7:0]            b;
      logic [DONE_WIDTH-1:0] closed;
      tally_t                t;
      lanes  = (cnt > MAX_LANES) ? MAX_LANES : int'(cnt);
      closed = '0;
      for (int i = 0; i < lanes; i++) begin
         b = d[8*i +: 8];
         if (blank(b)) begin
            if (in_word) begin
               word_total = bump(word_total);
               closed++;
               in_word = 1'b0;
            end
         end else if (!in_word) begin
            in_word   = 1'b1;
            cur_start = byte_pos;
            cur_len   = 1;
         end else begin
            cur_len = bump(cur_len);
         end
         byte_pos = bump(byte_pos);
      end
      // last flag flushes a text word still open
      if (fin && in_word) begin
         word_total = bump(word_total);
         closed++;
         in_word = 1'b0;
      end
      t.total_words     = word_total;
      t.words_completed = closed;
      t.open_word       = in_word;
      t.latest_length   = cur_len;
      t.latest_start    = cur_start;
      tally_q.push_back(t);
   endtask

   task automatic match(input string field, input logic [OUT_WIDTH-1:0] exp_v,
                        input logic [OUT_WIDTH-1:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %0d, actual %0d", field, exp_v, got_v);
         fail_count++;
      end
   endtask

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      if (reset) begin
         in_word    = 1'b0;
         word_total = '0;
         cur_len    = '0;
         cur_start  = '0;
         byte_pos   = '0;
         tally_q.delete();
      end else begin
         if (req.valid && req.ready)
            scan_word(req.data_bytes, req.valid_count, req.last_item);
         if (rsp.valid && rsp.ready) begin
            if (tally_q.size() == 0) begin
               $error("response word with no request word waiting");
               fail_count++;
            end else begin
               want = tally_q.pop_front();
               match("total_words", want.total_words, rsp.total_words);
               match("words_completed", OUT_WIDTH'(want.words_completed),
                     OUT_WIDTH'(rsp.words_completed));
               match("open_word", OUT_WIDTH'(want.open_word), OUT_WIDTH'(rsp.open_word));
               match("latest_length", want.latest_length, rsp.latest_length);
               match("latest_start", want.latest_start, rsp.latest_start);
            end
         end
      end
      expect_depth = tally_q.size();
   end

endmodule

FILE: tb/sv/whitespace_word_counter_tb.sv
// Top of the whitespace word counter testbench: clock, reset, request stimulus and
// response back-pressure, watchdog and verdict.
// Depends on wwc_pkg, wwc_if, whitespace_word_counter and whitespace_word_counter_checker.
module whitespace_word_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wwc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RAND_PER_PHASE = 150;
   localparam int TAIL_CYCLES    = 8;

   logic clock;
   logic reset;
   int   fail_count;
   int   expect_depth;
   int   send_idle;
   int   recv_stall;
   int   quiet_run;

   logic [7:0] blanks[4] = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR};

   wwc_req_if req_chan ();
   wwc_rsp_if rsp_chan ();

   whitespace_word_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   whitespace_word_counter_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .fail_count   (fail_count),
      .expect_depth (expect_depth)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
   end

   // Watchdog: ends the run after too long without any accepted word
   initial begin
      quiet_run = 0;
      while (quiet_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_run = 0;
         else
            quiet_run++;
      end
      $display("Verification failed");
      $finish;
   end

   // Text packed into lanes, byte 0 first; lanes past the text hold junk
   function automatic logic [DATA_WIDTH-1:0] text(input string s);
      logic [DATA_WIDTH-1:0] w;
      w = {$urandom, $urandom};
      for (int i = 0; i < s.len() && i < MAX_LANES; i++)
         w[8*i +: 8] = s[i];
      return w;
   endfunction

   // Random lanes with a given share of whitespace
   function automatic logic [DATA_WIDTH-1:0] rand_text(input int blank_pct);
      logic [DATA_WIDTH-1:0] w;
      for (int i = 0; i < MAX_LANES; i++) begin
         if ($urandom_range(99) < blank_pct)
            w[8*i +: 8] = blanks[$urandom_range(3)];
         else
            w[8*i +: 8] = 8'($urandom_range(255));
      end
      return w;
   endfunction

   // Offer one request word after an optional gap, return once it is taken
   task automatic put(input logic [DATA_WIDTH-1:0] d, input logic [VCOUNT_WIDTH-1:0] cnt,
                      input logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_bytes  <= d;
      req_chan.valid_count <= cnt;
      req_chan.last_item   <= fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic directed_words();
      put(text("        "), 4'd8, 1'b0);               // only whitespace, nothing open
      put(text("ab"), 4'd0, 1'b1);                     // empty last word, nothing open
      put(text("hello wo"), 4'd8, 1'b0);               // text word left open
      put(text("rld\tfoo\n"), 4'd8, 1'b0);             // carried text word closes
      put(text("xyz"), 4'd3, 1'b0);                    // short tail, junk beyond
      put(text("qq"), 4'd0, 1'b0);                     // empty, text word stays open
      put(text("q"), 4'd0, 1'b1);                      // empty last closes it
      put(text("word"), 4'd4, 1'b0);
      put(64'h64_0D_63_0A_62_09_61_20, 4'd8, 1'b1);    // five text words in one
      put(64'h0, 4'd8, 1'b0);                          // NUL bytes are not whitespace
      put('1, 4'd8, 1'b0);
      put('1, 4'd15, 1'b0);                            // count above lane total
      put(text("\n \t ab c"), 4'd9, 1'b0);
      put(64'h21_1F_0E_0C_0B_08_20_0A, 4'd8, 1'b0);    // bytes next to whitespace codes
      put(64'h0D_21_20_1F_09_0E_0A_0C, 4'd8, 1'b1);
      put(text("tail"), 4'd4, 1'b1);
      put(text("  "), 4'd2, 1'b1);                     // last with nothing open
      put(text("a"), 4'd1, 1'b0);                      // stream goes on after last
      put(text("abcdefgh"), 4'd12, 1'b1);
      put('1, 4'd0, 1'b0);
   endtask

   // Random text: runs of dense or sparse whitespace so text words span words
   task automatic random_words(input int n);
      int                      blank_pct;
      logic [VCOUNT_WIDTH-1:0] cnt;
      blank_pct = 30;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(4))
               0:       blank_pct = 0;
               1:       blank_pct = 10;
               2:       blank_pct = 30;
               3:       blank_pct = 60;
               default: blank_pct = 100;
            endcase
         end
         if ($urandom_range(9) < 7)
            cnt = VCOUNT_WIDTH'(8);
         else
            cnt = VCOUNT_WIDTH'($urandom_range(15));
         put(rand_text(blank_pct), cnt, ($urandom_range(99) < 8));
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset                = 1'b1;
      send_idle            = 0;
      recv_stall           = 0;
      req_chan.valid       = 1'b0;
      req_chan.data_bytes  = '0;
      req_chan.valid_count = '0;
      req_chan.last_item   = 1'b0;
      rsp_chan.ready       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed_words();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle = 0;  recv_stall = 0;  end
            1:       begin send_idle = 75; recv_stall = 0;  end
            2:       begin send_idle = 0;  recv_stall = 75; end
            default: begin send_idle = 15; recv_stall = 15; end
         endcase
         random_words(RAND_PER_PHASE);
      end
      req_chan.valid <= 1'b0;

      // let the checker see the last request, drain responses, then settle
      @(negedge clock);
      while (expect_depth != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
design/wwc_pkg.sv
design/wwc_if.sv
design/wwc_lane.sv
design/wwc_scan.sv
design/wwc_merge.sv
design/whitespace_word_counter.sv
tb/sv/whitespace_word_counter_checker.sv
tb/sv/whitespace_word_counter_tb.sv
